// ===== src/render_pass_dependency_scoreboard_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the render pass dependency scoreboard
// Short forms for clocked implication checks that report through $error.
// ----------------------------------------------------------------------------
`ifndef RENDER_PASS_DEPENDENCY_SCOREBOARD_ASSERT_SVH
`define RENDER_PASS_DEPENDENCY_SCOREBOARD_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define RPDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define RPDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/rpds_pkg.sv =====
// ----------------------------------------------------------------------------
// rpds_pkg
// Codes, types and fixed constants of the render pass dependency scoreboard.
// ----------------------------------------------------------------------------
`default_nettype none

package rpds_pkg;

  // Request operation codes
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_ERASE    = 2'd1;
  localparam logic [1:0] OP_DANGLING = 2'd2;
  localparam logic [1:0] OP_COMPLETE = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_ADD   = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_LIST  = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_FULL   = 2'd1;
  localparam logic [1:0] STATUS_ABSENT = 2'd2;

  localparam int         MASK_W    = 32;
  localparam int         CNT_W     = 5;
  localparam logic [4:0] COUNT_MAX = 5'd31;
  localparam logic [4:0] MAX_LIST  = 5'd16;

  typedef struct packed {
    logic [MASK_W-1:0] reads;
    logic [MASK_W-1:0] writes;
  } pass_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERASE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// ===== src/render_pass_dependency_scoreboard.sv =====
// ----------------------------------------------------------------------------
// render_pass_dependency_scoreboard
// One request at a time. Add: one result in the cycle after the request; a valid
// erase: one result once its masks are read. Query: one pass slot per cycle
// unless the output holds it, via the pass memory's single read port.
// Reset clears slot valid bits, counts, slot pointer and handshake state; the
// pass memory is not cleared, as the data of invalid slots is never used.
// ----------------------------------------------------------------------------
`default_nettype none

module render_pass_dependency_scoreboard #(
  parameter int RESOURCE_COUNT = 32,
  parameter int PASS_SLOTS     = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request channel
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  op,
  input  wire logic [3:0]  slot_sel,
  input  wire logic [31:0] read_mask,
  input  wire logic [31:0] write_mask,
  // result channel
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic [1:0]       kind,
  output logic [3:0]       slot_out,
  output logic [1:0]       status,
  output logic             backbuffer_written,
  output logic             is_last
);

  // Only the first 32 resources fit the masks; the rest are never tracked.
  localparam int LIVE = (RESOURCE_COUNT < rpds_pkg::MASK_W) ? RESOURCE_COUNT
                                                            : rpds_pkg::MASK_W;
  // Slot index width and pointer width (pointer must reach PASS_SLOTS itself).
  localparam int SW = (PASS_SLOTS > 1) ? $clog2(PASS_SLOTS) : 1;
  localparam int PW = $clog2(PASS_SLOTS + 1);
  localparam logic [PW-1:0] SLOT_LIM = PW'(PASS_SLOTS);

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  rpds_pkg::state_t state, state_next;

  // Pass table: one synchronous memory, one write and one read port.
  rpds_pkg::pass_entry_t pass_mem [PASS_SLOTS];
  rpds_pkg::pass_entry_t mem_q;
  logic                  mem_re;
  logic [SW-1:0]         mem_raddr;

  logic [PASS_SLOTS-1:0] pass_valid;
  logic [PW-1:0]         next_slot;

  // Per-resource pending reader and writer counts; each lane at its own place.
  logic [rpds_pkg::CNT_W-1:0] reader_count [LIVE];
  logic [rpds_pkg::CNT_W-1:0] writer_count [LIVE];
  logic [LIVE-1:0]            reader_nz;
  logic [LIVE-1:0]            writer_nz;

  // Scan control
  logic [1:0]    op_q;
  logic [PW-1:0] scan_ptr;
  logic          eval_vld;
  logic [SW-1:0] eval_slot;
  logic          pend_vld;
  logic [SW-1:0] pend_slot;
  logic [4:0]    match_cnt;
  logic [SW-1:0] erase_idx;

  // --------------------------------------------------------------------------
  // Combinational control
  // --------------------------------------------------------------------------
  logic          accept;
  logic          res_free;
  logic [SW-1:0] sel_idx;
  logic          sel_ok;
  logic          table_full;
  logic          busy;
  logic          eff_hit;
  logic          blocked;
  logic          can_issue;

  logic          do_add;
  logic          do_erase;
  logic          scan_start;
  logic          advance;
  logic          push;
  logic [1:0]    push_kind;
  logic [3:0]    push_slot;
  logic [1:0]    push_status;
  logic          push_bb;
  logic          push_last;
  logic          bb_now;
  logic          bb_after_erase;

  always_comb begin
    for (int r = 0; r < LIVE; r++) begin
      reader_nz[r] = (reader_count[r] != '0);
      writer_nz[r] = (writer_count[r] != '0);
    end
  end

  // Hold new requests while busy or while a finished result cannot move out.
  assign res_free   = !res_valid || !res_stall;
  assign req_stall  = (state != rpds_pkg::ST_IDLE) || !res_free;
  assign accept     = req_valid && !req_stall;

  assign sel_idx    = SW'(slot_sel);
  assign sel_ok     = (int'(slot_sel) < PASS_SLOTS) && pass_valid[sel_idx];
  assign table_full = (next_slot >= SLOT_LIM);

  assign bb_now         = writer_nz[0];
  assign bb_after_erase = writer_nz[0] &&
                          !(mem_q.writes[0] && (writer_count[0] == 5'd1));

  // A dangling pass must not write the backbuffer, which always counts as read.
  always_comb begin
    if (op_q == rpds_pkg::OP_DANGLING) begin
      busy = mem_q.writes[0] || (|(mem_q.writes[LIVE-1:0] & reader_nz));
    end else begin
      busy = |(mem_q.reads[LIVE-1:0] & writer_nz);
    end
  end

  // Ignore evaluations that arrive after the list has filled up.
  assign eff_hit   = eval_vld && pass_valid[eval_slot] && !busy &&
                     (match_cnt != rpds_pkg::MAX_LIST);
  // A second match needs the output register to retire the pending one.
  assign blocked   = eff_hit && pend_vld && !res_free;
  assign can_issue = (scan_ptr < SLOT_LIM) && (match_cnt != rpds_pkg::MAX_LIST);

  always_comb begin
    state_next  = state;
    do_add      = 1'b0;
    do_erase    = 1'b0;
    scan_start  = 1'b0;
    advance     = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = scan_ptr[SW-1:0];
    push        = 1'b0;
    push_kind   = rpds_pkg::KIND_ADD;
    push_slot   = 4'd0;
    push_status = rpds_pkg::STATUS_OK;
    push_bb     = bb_now;
    push_last   = 1'b1;

    unique case (state)
      rpds_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op)
            rpds_pkg::OP_ADD: begin
              push      = 1'b1;
              push_kind = rpds_pkg::KIND_ADD;
              if (table_full) begin
                push_status = rpds_pkg::STATUS_FULL;
              end else begin
                do_add    = 1'b1;
                push_slot = 4'(next_slot);
                // Raising a count from any value leaves it nonzero.
                push_bb   = bb_now || write_mask[0];
              end
            end
            rpds_pkg::OP_ERASE: begin
              if (sel_ok) begin
                mem_re     = 1'b1;
                mem_raddr  = sel_idx;
                state_next = rpds_pkg::ST_ERASE;
              end else begin
                push        = 1'b1;
                push_kind   = rpds_pkg::KIND_ERASE;
                push_status = rpds_pkg::STATUS_ABSENT;
              end
            end
            rpds_pkg::OP_DANGLING, rpds_pkg::OP_COMPLETE: begin
              scan_start = 1'b1;
              state_next = rpds_pkg::ST_SCAN;
            end
            default: begin
              state_next = rpds_pkg::ST_IDLE;
            end
          endcase
        end
      end

      rpds_pkg::ST_ERASE: begin
        // Pass masks are on the memory output now; lower the counts.
        if (res_free) begin
          do_erase   = 1'b1;
          push       = 1'b1;
          push_kind  = rpds_pkg::KIND_ERASE;
          push_bb    = bb_after_erase;
          state_next = rpds_pkg::ST_IDLE;
        end
      end

      rpds_pkg::ST_SCAN: begin
        if (!blocked) begin
          advance = 1'b1;
          if (eff_hit && pend_vld) begin
            // A later match exists, so the pending one is not last.
            push      = 1'b1;
            push_kind = rpds_pkg::KIND_LIST;
            push_slot = 4'(pend_slot);
            push_last = 1'b0;
          end
          if (can_issue) begin
            mem_re    = 1'b1;
            mem_raddr = scan_ptr[SW-1:0];
          end else begin
            state_next = rpds_pkg::ST_FLUSH;
          end
        end
      end

      rpds_pkg::ST_FLUSH: begin
        if (res_free) begin
          push = 1'b1;
          if (pend_vld) begin
            push_kind = rpds_pkg::KIND_LIST;
            push_slot = 4'(pend_slot);
          end else begin
            push_kind = rpds_pkg::KIND_NONE;
          end
          state_next = rpds_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rpds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpds_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // --------------------------------------------------------------------------
  // Pass memory
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (do_add) begin
      pass_mem[SW'(next_slot)] <= '{reads: read_mask, writes: write_mask};
    end
    if (mem_re) begin
      mem_q <= pass_mem[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Table bookkeeping and counts
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_valid <= '0;
      next_slot  <= '0;
      for (int r = 0; r < LIVE; r++) begin
        reader_count[r] <= '0;
        writer_count[r] <= '0;
      end
    end else begin
      if (do_add) begin
        pass_valid[SW'(next_slot)] <= 1'b1;
        next_slot <= next_slot + PW'(1);
        // Saturate at the top.
        for (int r = 0; r < LIVE; r++) begin
          if (read_mask[r] && (reader_count[r] != rpds_pkg::COUNT_MAX)) begin
            reader_count[r] <= reader_count[r] + 5'd1;
          end
          if (write_mask[r] && (writer_count[r] != rpds_pkg::COUNT_MAX)) begin
            writer_count[r] <= writer_count[r] + 5'd1;
          end
        end
      end
      if (do_erase) begin
        pass_valid[erase_idx] <= 1'b0;
        // Stop at zero.
        for (int r = 0; r < LIVE; r++) begin
          if (mem_q.reads[r] && reader_nz[r]) begin
            reader_count[r] <= reader_count[r] - 5'd1;
          end
          if (mem_q.writes[r] && writer_nz[r]) begin
            writer_count[r] <= writer_count[r] - 5'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      erase_idx <= sel_idx;
      op_q      <= op;
    end
    if (advance) begin
      if (mem_re) begin
        eval_slot <= scan_ptr[SW-1:0];
      end
      if (eff_hit) begin
        pend_slot <= eval_slot;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scan pipeline: read slot, evaluate next cycle, keep one match pending
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_ptr  <= '0;
      eval_vld  <= 1'b0;
      pend_vld  <= 1'b0;
      match_cnt <= '0;
    end else if (scan_start) begin
      scan_ptr  <= '0;
      eval_vld  <= 1'b0;
      pend_vld  <= 1'b0;
      match_cnt <= '0;
    end else if (advance) begin
      eval_vld <= mem_re;
      if (mem_re) begin
        scan_ptr <= scan_ptr + PW'(1);
      end
      if (eff_hit) begin
        pend_vld  <= 1'b1;
        match_cnt <= match_cnt + 5'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (push) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      kind               <= push_kind;
      slot_out           <= push_slot;
      status             <= push_status;
      backbuffer_written <= push_bb;
      is_last            <= push_last;
    end
  end

endmodule

`default_nettype wire

// ===== src/rpds_checker.sv =====
// ----------------------------------------------------------------------------
// rpds_checker
// Port-level checks of the render pass dependency scoreboard, bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "render_pass_dependency_scoreboard_assert.svh"

module rpds_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        res_valid,
  input wire logic        res_stall,
  input wire logic [1:0]  kind,
  input wire logic [3:0]  slot_out,
  input wire logic [1:0]  status,
  input wire logic        backbuffer_written,
  input wire logic        is_last
);

  logic [9:0] res_bus;
  logic       res_held;
  logic       req_take;
  logic       res_room;
  logic       ack_res;
  logic       none_res;
  logic       none_ok;

  assign res_bus  = {kind, slot_out, status, backbuffer_written, is_last};
  assign res_held = res_valid && res_stall;
  assign req_take = req_valid && !req_stall;
  assign res_room = !res_valid || !res_stall;
  assign ack_res  = res_valid &&
                    (kind == rpds_pkg::KIND_ADD || kind == rpds_pkg::KIND_ERASE);
  assign none_res = res_valid && (kind == rpds_pkg::KIND_NONE);
  assign none_ok  = is_last && (slot_out == 4'd0) && (status == rpds_pkg::STATUS_OK);

  // Hold a stalled result.
  `RPDS_ASSERT_NXT(a_res_hold, res_held, res_valid && $stable(res_bus), "stalled result moved")

  // Take a request only when the output register can move.
  `RPDS_ASSERT_IMP(a_req_needs_room, req_take, res_room, "request taken with output blocked")

  // Add and erase acknowledge with a single result.
  `RPDS_ASSERT_IMP(a_ack_single, ack_res, is_last, "ack not marked last")

  // An empty query answers once, with slot zero and status ok.
  `RPDS_ASSERT_IMP(a_none_form, none_res, none_ok, "bad empty query result")

endmodule

bind render_pass_dependency_scoreboard rpds_checker u_rpds_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req_valid),
  .req_stall          (req_stall),
  .res_valid          (res_valid),
  .res_stall          (res_stall),
  .kind               (kind),
  .slot_out           (slot_out),
  .status             (status),
  .backbuffer_written (backbuffer_written),
  .is_last            (is_last)
);

`default_nettype wire

// ===== bench/render_pass_dependency_scoreboard_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// render_pass_dependency_scoreboard_tb
// Drives add, erase and query requests through the valid/stall request channel
// and checks every result against a behavioral copy of the pass table and the
// per-resource reader and writer counts. A directed table runs first and covers
// field extremes, absent erases, backbuffer tracking and empty queries. A random
// phase follows that fills the table past full and drains it again. Both sides
// insert random gaps. The receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module render_pass_dependency_scoreboard_tb;

  localparam int PASS_SLOTS   = 16;
  localparam int RESOURCES    = 32;
  localparam int RANDOM_ITEMS = 405;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 25;     // one full query scan plus margin
  localparam int CYCLE_LIMIT  = 1000000;

  // One result as the block presents it
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot;
    logic [1:0] status;
    logic       bb;
    logic       last;
  } result_t;

  // One directed request; typed rows carry their own single expected result
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  sel;
    logic [31:0] rd;
    logic [31:0] wr;
    logic        typed;
    result_t     want;
  } stim_row_t;

  localparam result_t NO_RESULT = '0;
  localparam int      DIRECTED_ROWS = 25;

  // Walk the table from empty: backbuffer writers come and go, slot 0 is
  // erased three times, and slots 0..6 are used, so the random phase finds the
  // remaining slots free and runs into a full table on its own.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // empty table: queries find nothing, erases find nothing
    '{rpds_pkg::OP_DANGLING, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_NONE,  4'd0, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_COMPLETE, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_NONE,  4'd0, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_ERASE,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_ABSENT, 1'b0, 1'b1}},
    '{rpds_pkg::OP_ERASE,    4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_ABSENT, 1'b0, 1'b1}},
    // all-ones pass, then an empty pass
    '{rpds_pkg::OP_ADD,      4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd0, rpds_pkg::STATUS_OK,     1'b1, 1'b1}},
    '{rpds_pkg::OP_ADD,      4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd1, rpds_pkg::STATUS_OK,     1'b1, 1'b1}},
    '{rpds_pkg::OP_DANGLING, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    '{rpds_pkg::OP_COMPLETE, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    // backbuffer writer, top resource reader, top resource writer
    '{rpds_pkg::OP_ADD,      4'd0,  32'h0000_0002, 32'h0000_0001, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd2, rpds_pkg::STATUS_OK,     1'b1, 1'b1}},
    '{rpds_pkg::OP_ADD,      4'd0,  32'h8000_0000, 32'h0000_0004, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd3, rpds_pkg::STATUS_OK,     1'b1, 1'b1}},
    '{rpds_pkg::OP_ADD,      4'd0,  32'h0000_0001, 32'h8000_0000, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd4, rpds_pkg::STATUS_OK,     1'b1, 1'b1}},
    '{rpds_pkg::OP_DANGLING, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    '{rpds_pkg::OP_COMPLETE, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    // erase slot 0; slot 2 still writes the backbuffer, then erase it again
    '{rpds_pkg::OP_ERASE,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_OK,     1'b1, 1'b1}},
    '{rpds_pkg::OP_ERASE,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_ABSENT, 1'b1, 1'b1}},
    '{rpds_pkg::OP_DANGLING, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    '{rpds_pkg::OP_COMPLETE, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    // last backbuffer writer leaves
    '{rpds_pkg::OP_ERASE,    4'd2,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_ADD,      4'd0,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd5, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_ADD,      4'd0,  32'hAAAA_AAAA, 32'h5555_5554, 1'b1,
      '{rpds_pkg::KIND_ADD,   4'd6, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_COMPLETE, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    '{rpds_pkg::OP_DANGLING, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
    '{rpds_pkg::OP_ERASE,    4'd4,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_ERASE,    4'd1,  32'h0000_0000, 32'h0000_0000, 1'b1,
      '{rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_OK,     1'b0, 1'b1}},
    '{rpds_pkg::OP_DANGLING, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT}
  };

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  op;
  logic [3:0]  slot_sel;
  logic [31:0] read_mask;
  logic [31:0] write_mask;
  logic        res_valid;
  logic        res_stall;
  logic [1:0]  kind;
  logic [3:0]  slot_out;
  logic [1:0]  status;
  logic        backbuffer_written;
  logic        is_last;

  render_pass_dependency_scoreboard #(
    .RESOURCE_COUNT(RESOURCES),
    .PASS_SLOTS    (PASS_SLOTS)
  ) dut (
    .clk               (clk),
    .rst               (rst),
    .req_valid         (req_valid),
    .req_stall         (req_stall),
    .op                (op),
    .slot_sel          (slot_sel),
    .read_mask         (read_mask),
    .write_mask        (write_mask),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .kind              (kind),
    .slot_out          (slot_out),
    .status            (status),
    .backbuffer_written(backbuffer_written),
    .is_last           (is_last)
  );

  // Shadow copy of the pass table and the resource counts
  bit                         pass_live [PASS_SLOTS];
  logic [31:0]                pass_rd   [PASS_SLOTS];
  logic [31:0]                pass_wr   [PASS_SLOTS];
  logic [rpds_pkg::CNT_W-1:0] reader_cnt[RESOURCES];
  logic [rpds_pkg::CNT_W-1:0] writer_cnt[RESOURCES];
  int                         fill_ptr;

  result_t predicted[$];        // results of the request just accepted
  result_t pending_results[$];  // results still owed by the block

  int errors;
  int cycles = 0;
  bit quiet;          // no gaps on either side while set
  bit hold_off_req;   // ask the receiver for its one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up once the run is far past any correct duration.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("render_pass_dependency_scoreboard: mismatch");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ERROR %s", $time, what);
    errors++;
  endtask

  // Mostly zero, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Raise or lower the counts of every resource a pass names; saturate at
  // the top and stop at zero.
  function automatic void update_counts(input logic [31:0] rd, input logic [31:0] wr,
                                        input bit raise);
    for (int r = 0; r < RESOURCES; r++) begin
      if (rd[r]) begin
        if (raise) begin
          if (reader_cnt[r] != rpds_pkg::COUNT_MAX) reader_cnt[r] = reader_cnt[r] + 1'b1;
        end else if (reader_cnt[r] != 0) begin
          reader_cnt[r] = reader_cnt[r] - 1'b1;
        end
      end
      if (wr[r]) begin
        if (raise) begin
          if (writer_cnt[r] != rpds_pkg::COUNT_MAX) writer_cnt[r] = writer_cnt[r] + 1'b1;
        end else if (writer_cnt[r] != 0) begin
          writer_cnt[r] = writer_cnt[r] - 1'b1;
        end
      end
    end
  endfunction

  // Append one predicted result; the backbuffer flag follows the counts.
  function automatic void add_predicted(input logic [1:0] k, input logic [3:0] s,
                                        input logic [1:0] st, input logic l);
    result_t r;
    r = '{k, s, st, writer_cnt[0] != 0, l};
    predicted.insert(predicted.size(), r);
  endfunction

  // Apply one request to the shadow table and list the results it causes.
  function automatic void compute_results(input logic [1:0] req_op, input logic [3:0] sel,
                                          input logic [31:0] rd, input logic [31:0] wr);
    int found;
    bit busy;
    predicted.delete();
    case (req_op)
      rpds_pkg::OP_ADD: begin
        if (fill_ptr >= PASS_SLOTS) begin
          add_predicted(rpds_pkg::KIND_ADD, 4'd0, rpds_pkg::STATUS_FULL, 1'b1);
        end else begin
          pass_live[fill_ptr] = 1'b1;
          pass_rd[fill_ptr]   = rd;
          pass_wr[fill_ptr]   = wr;
          update_counts(rd, wr, 1'b1);
          add_predicted(rpds_pkg::KIND_ADD, 4'(fill_ptr), rpds_pkg::STATUS_OK, 1'b1);
          fill_ptr++;
        end
      end
      rpds_pkg::OP_ERASE: begin
        if (!pass_live[sel]) begin
          add_predicted(rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_ABSENT, 1'b1);
        end else begin
          update_counts(pass_rd[sel], pass_wr[sel], 1'b0);
          pass_live[sel] = 1'b0;
          add_predicted(rpds_pkg::KIND_ERASE, 4'd0, rpds_pkg::STATUS_OK, 1'b1);
        end
      end
      default: begin
        // Dangling: no written resource is read, the backbuffer always is.
        // Complete: no read resource still has a writer.
        found = 0;
        for (int s = 0; s < PASS_SLOTS && found < rpds_pkg::MAX_LIST; s++) begin
          if (pass_live[s]) begin
            busy = 1'b0;
            for (int r = 0; r < RESOURCES; r++) begin
              if (req_op == rpds_pkg::OP_DANGLING) begin
                if (pass_wr[s][r] && (r == 0 || reader_cnt[r] != 0)) busy = 1'b1;
              end else begin
                if (pass_rd[s][r] && writer_cnt[r] != 0) busy = 1'b1;
              end
            end
            if (!busy) begin
              add_predicted(rpds_pkg::KIND_LIST, 4'(s), rpds_pkg::STATUS_OK, 1'b0);
              found++;
            end
          end
        end
        if (found == 0)
          add_predicted(rpds_pkg::KIND_NONE, 4'd0, rpds_pkg::STATUS_OK, 1'b1);
        else
          predicted[predicted.size() - 1].last = 1'b1;
      end
    endcase
  endfunction

  // Offer one request after a random gap, hold it until accepted, then
  // record what the block owes for it. Valid stays high across back-to-back
  // requests, so it gets one assignment per step.
  task automatic send_request(input logic [1:0] req_op, input logic [3:0] sel,
                              input logic [31:0] rd, input logic [31:0] wr,
                              input logic typed, input result_t want);
    int gap;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid  <= 1'b1;
    op         <= req_op;
    slot_sel   <= sel;
    read_mask  <= rd;
    write_mask <= wr;
    do @(posedge clk); while (req_stall);
    compute_results(req_op, sel, rd, wr);
    if (typed) begin
      pending_results.insert(pending_results.size(), want);
    end else begin
      foreach (predicted[i]) pending_results.insert(pending_results.size(), predicted[i]);
    end
  endtask

  // Receiver: random stalls, free-running while quiet, and one long hold-off
  // on request so the request side backs up behind an undelivered result.
  initial begin
    int  hold_left;
    int  stall_left;
    bit  hold_taken;
    res_stall  <= 1'b0;
    hold_left  = 0;
    stall_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        res_stall <= 1'b1;
        hold_left--;
      end else if (quiet) begin
        res_stall <= 1'b0;
      end else begin
        if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        res_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // Compare each accepted result with the oldest one owed, field by field.
  always @(posedge clk) begin
    result_t want;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: kind %0d slot %0d",
                                  kind, slot_out));
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
        if (slot_out !== want.slot)
          report_mismatch($sformatf("slot_out got %0d want %0d", slot_out, want.slot));
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", status, want.status));
        if (backbuffer_written !== want.bb)
          report_mismatch($sformatf("backbuffer_written got %0b want %0b",
                                    backbuffer_written, want.bb));
        if (is_last !== want.last)
          report_mismatch($sformatf("is_last got %0b want %0b", is_last, want.last));
      end
    end
  end

  // Stimulus: directed table, then random requests, then drain.
  initial begin
    int          pick;
    int          start;
    logic [1:0]  rop;
    logic [3:0]  rsel;
    logic [31:0] rrd;
    logic [31:0] rwr;

    rst          <= 1'b1;
    req_valid    <= 1'b0;
    op           <= rpds_pkg::OP_ADD;
    slot_sel     <= 4'd0;
    read_mask    <= 32'd0;
    write_mask   <= 32'd0;
    quiet        = 1'b0;
    hold_off_req = 1'b0;
    errors       = 0;
    fill_ptr     = 0;
    foreach (pass_live[s]) begin
      pass_live[s] = 1'b0;
      pass_rd[s]   = 32'd0;
      pass_wr[s]   = 32'd0;
    end
    foreach (reader_cnt[r]) begin
      reader_cnt[r] = '0;
      writer_cnt[r] = '0;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k])
      send_request(DIRECTED[k].op, DIRECTED[k].sel, DIRECTED[k].rd, DIRECTED[k].wr,
                   DIRECTED[k].typed, DIRECTED[k].want);

    // Random phase: adds run the table into full, erases mostly hit live
    // passes so the table drains slowly, and queries see a changing mix.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_off_req = 1'b1;
      quiet = (i >= 250 && i < 320);
      pick  = $urandom_range(0, 99);
      rsel  = 4'($urandom_range(0, 15));
      rrd   = $urandom;
      rwr   = $urandom;
      if (pick < 12) begin
        rop = rpds_pkg::OP_ADD;
        // keep most passes on a few resources with disjoint read and write sets
        if ($urandom_range(0, 9) != 0) begin
          rrd = $urandom_range(0, 255) & $urandom_range(0, 255);
          rwr = $urandom_range(0, 255) & $urandom_range(0, 255) & ~rrd;
        end
      end else if (pick < 20) begin
        rop = rpds_pkg::OP_ERASE;
        if ($urandom_range(0, 1) == 1) begin
          start = $urandom_range(0, PASS_SLOTS - 1);
          for (int k = 0; k < PASS_SLOTS; k++) begin
            if (pass_live[(start + k) % PASS_SLOTS]) begin
              rsel = 4'((start + k) % PASS_SLOTS);
              break;
            end
          end
        end
      end else begin
        rop = (pick < 60) ? rpds_pkg::OP_DANGLING : rpds_pkg::OP_COMPLETE;
      end
      send_request(rop, rsel, rrd, rwr, 1'b0, NO_RESULT);
    end
    quiet = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("render_pass_dependency_scoreboard: match");
    else
      $display("render_pass_dependency_scoreboard: mismatch");
    $finish;
  end

endmodule
